// ===== hw/rtl/bxavg_pkg.sv =====
// Shared types and constants for the boxcar average decimator.
package bxavg_pkg;

    // Width of the rate register, fixed by the register map.
    localparam int RATE_W = 9;

    // Controller states.
    typedef enum logic [1:0] {
        ST_ACC,     // taking samples
        ST_DIV,     // shift-subtract divide in progress
        ST_FIN      // quotient ready, waiting for the output register
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic accum;     // accepted beat, not the last of the block
        logic start;     // accepted beat closing the block: load divider
        logic step;      // one divide iteration
        logic out_load;  // move the signed quotient to the output register
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last;      // current count plus one reaches the rate
        logic step_last; // divider on its final iteration
        logic out_free;  // output register empty or draining this cycle
    } sts_t;

endpackage

// ===== hw/rtl/bxavg_ctrl.sv =====
// Controller state machine for the boxcar average decimator.
module bxavg_ctrl
    import bxavg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC: begin
                if (s_valid && sts.last) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.step_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_ACC: begin
                s_ready   = 1'b1;
                cmd.accum = s_valid && !sts.last;
                cmd.start = s_valid && sts.last;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
            end
            ST_FIN: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bxavg_dp.sv =====
// Datapath: rate register, accumulator, shift-subtract divider, output register.
module bxavg_dp
    import bxavg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_RATE    = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [RATE_W-1:0]             cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_average_out,
    input  cmd_t                          cmd,
    output sts_t                          sts
);

    // Sum of up to 2**RATE_W - 1 samples.
    localparam int SUM_W  = SAMPLE_BITS + RATE_W;
    localparam int STEP_W = $clog2(SUM_W);

    logic [RATE_W-1:0]             rate_reg,  rate_next;
    logic signed [SUM_W-1:0]       sum_reg,   sum_next;
    logic [RATE_W-1:0]             count_reg, count_next;
    logic [RATE_W-1:0]             rem_reg,   rem_next;
    logic [SUM_W-1:0]              quo_reg,   quo_next;
    logic                          neg_reg,   neg_next;
    logic [STEP_W-1:0]             step_reg,  step_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_reg,   out_next;

    logic [RATE_W-1:0]             cfg_rate;
    logic signed [SUM_W-1:0]       total;
    logic [SUM_W-1:0]              total_mag;
    logic [RATE_W:0]               trial;
    logic [RATE_W:0]               trial_diff;
    logic                          trial_ge;
    logic [SUM_W-1:0]              quo_signed;

    // Zero acts as one, anything above MAX_RATE as MAX_RATE.
    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_rate = RATE_W'(1);
        end else if (32'(cfg_wr_data) > 32'(MAX_RATE)) begin
            cfg_rate = RATE_W'(MAX_RATE);
        end else begin
            cfg_rate = cfg_wr_data;
        end
    end

    assign total     = sum_reg + SUM_W'(s_sample_in);
    assign total_mag = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);

    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, rate_reg};
    assign trial_ge   = (trial >= {1'b0, rate_reg});
    assign quo_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

    always_comb begin
        rate_next      = rate_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        step_next      = step_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cfg_wr_en) begin
            rate_next  = cfg_rate;
            sum_next   = '0;
            count_next = '0;
        end else if (cmd.accum) begin
            sum_next   = total;
            count_next = count_reg + RATE_W'(1);
        end else if (cmd.start) begin
            sum_next   = '0;
            count_next = '0;
        end

        if (cmd.start) begin
            rem_next  = '0;
            quo_next  = total_mag;
            neg_next  = total[SUM_W-1];
            step_next = STEP_W'(SUM_W - 1);
        end else if (cmd.step) begin
            rem_next  = trial_ge ? trial_diff[RATE_W-1:0] : trial[RATE_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], trial_ge};
            step_next = step_reg - STEP_W'(1);
        end

        if (cmd.out_load) begin
            out_next       = quo_signed[SAMPLE_BITS-1:0];
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg      <= RATE_W'(1);
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rate_reg      <= rate_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
        out_reg  <= out_next;
    end

    assign sts.last      = ({1'b0, count_reg} + (RATE_W + 1)'(1)) == {1'b0, rate_reg};
    assign sts.step_last = (step_reg == '0);
    assign sts.out_free  = !out_valid_reg || m_ready;

    assign m_valid       = out_valid_reg;
    assign m_average_out = out_reg;

endmodule

// ===== hw/rtl/boxcar_average_decimator.sv =====
// Top level of the boxcar average decimator: controller plus datapath.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------
//   input    | s_valid / s_ready  | s_sample_in   (signed SAMPLE_BITS)
//   result   | m_valid / m_ready  | m_average_out (signed SAMPLE_BITS)
//   config   | cfg_wr_en          | cfg_wr_data   (drop rate, 9 bits)
//
// A beat that does not close a block is added to the running sum and the
// next beat can follow at once. The beat that closes a block is accepted,
// then the shift-subtract divider works through the SAMPLE_BITS + 9 bit
// sum bit by bit, then the signed mean is loaded into the output
// register. s_ready is low during the divide and while a finished
// mean waits for a full output register to drain. The output register
// decouples the sides: a pending mean does not block new input beats.
// Synchronous reset sets the rate to 1 and clears sum, count and m_valid.
module boxcar_average_decimator
    import bxavg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_RATE    = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // rate register write
    input  logic                          cfg_wr_en,
    input  logic [RATE_W-1:0]             cfg_wr_data,
    // sample input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    // averaged output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_average_out
);

    cmd_t cmd;
    sts_t sts;

    // Sequencing: accumulate, divide, hand off.
    bxavg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Rate register, running sum, divider and output register.
    bxavg_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_RATE    (MAX_RATE)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_sample_in   (s_sample_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_average_out (m_average_out),
        .cmd           (cmd),
        .sts           (sts)
    );

    // A new mean never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten while full");

    // Closing a block stops input until the mean is loaded into the output register.
    a_start_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> !s_ready)
        else $error("input accepted during divide");

    // A loaded mean shows up on the result port in the next cycle.
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded mean not presented");

endmodule
